### hw/rtl/rdlf_pkg.sv
// Shared constants for the lab-frame direction rotation block.
package rdlf_pkg;

   localparam int FIELD_W = 32;
   localparam int FRAC_BITS_DEFAULT = 30;
   localparam int IN_FIELDS = 6;
   localparam int OUT_FIELDS = 3;

endpackage

### hw/rtl/rdlf_sqrt.sv
// Pipelined rounded integer square root, one result bit per stage, with a side payload.
module rdlf_sqrt
   import rdlf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [2*FRAC_BITS+1:0]   in_sum,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic [FRAC_BITS:0]       out_root,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int SW = 2 * FRAC_BITS + 2;
   localparam int RW = FRAC_BITS + 1;
   localparam int STEPS = FRAC_BITS + 1;

   logic              v_s    [STEPS+1];
   logic [SW-1:0]     rem_s  [STEPS+1];
   logic [SW-1:0]     res_s  [STEPS+1];
   logic [SIDE_W-1:0] side_s [STEPS+1];

   logic              out_valid_ff;
   logic [RW-1:0]     root_ff;
   logic [SIDE_W-1:0] side_out_ff;
   logic [SW-1:0]     root_in;

   assign v_s[0]    = in_valid;
   assign rem_s[0]  = in_sum;
   assign res_s[0]  = '0;
   assign side_s[0] = in_side;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam logic [SW-1:0] BIT_VAL = {{(SW-1){1'b0}}, 1'b1} << (2 * (STEPS - 1 - k));
      logic              v_ff;
      logic [SW-1:0]     rem_ff;
      logic [SW-1:0]     res_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [SW-1:0]     trial;
      logic [SW-1:0]     rem_in;
      logic [SW-1:0]     res_in;

      always_comb begin
         trial = res_s[k] + BIT_VAL;
         if (rem_s[k] >= trial) begin
            rem_in = rem_s[k] - trial;
            res_in = (res_s[k] >> 1) + BIT_VAL;
         end else begin
            rem_in = rem_s[k];
            res_in = res_s[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_s[k];
         end
         if (en) begin
            rem_ff  <= rem_in;
            res_ff  <= res_in;
            side_ff <= side_s[k];
         end
      end

      assign v_s[k+1]    = v_ff;
      assign rem_s[k+1]  = rem_ff;
      assign res_s[k+1]  = res_ff;
      assign side_s[k+1] = side_ff;
   end

   assign root_in = res_s[STEPS] + SW'(rem_s[STEPS] > res_s[STEPS]);

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (en) begin
         out_valid_ff <= v_s[STEPS];
      end
      if (en) begin
         root_ff     <= root_in[RW-1:0];
         side_out_ff <= side_s[STEPS];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_root  = root_ff;
   assign out_side  = side_out_ff;

endmodule

### hw/rtl/rdlf_div.sv
// Two-lane pipelined restoring divider with a shared divisor and an overflow flag per lane.
module rdlf_div
   import rdlf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT,
   parameter int SIDE_W = 1
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [2*FRAC_BITS+1:0]   in_num_a,
   input  logic [2*FRAC_BITS+1:0]   in_num_b,
   input  logic [FRAC_BITS:0]       in_den,
   input  logic [SIDE_W-1:0]        in_side,
   output logic                     out_valid,
   output logic [FRAC_BITS+2:0]     out_quo_a,
   output logic [FRAC_BITS+2:0]     out_quo_b,
   output logic                     out_ovf_a,
   output logic                     out_ovf_b,
   output logic [SIDE_W-1:0]        out_side
);

   localparam int PWD = FRAC_BITS + 1;
   localparam int QW = FRAC_BITS + 3;
   localparam int DW = PWD + QW;

   logic              v_s    [QW+1];
   logic [DW-1:0]     rema_s [QW+1];
   logic [DW-1:0]     remb_s [QW+1];
   logic [QW-1:0]     quoa_s [QW+1];
   logic [QW-1:0]     quob_s [QW+1];
   logic              ovfa_s [QW+1];
   logic              ovfb_s [QW+1];
   logic [PWD-1:0]    den_s  [QW+1];
   logic [SIDE_W-1:0] side_s [QW+1];

   logic              v0_ff;
   logic [DW-1:0]     rema0_ff;
   logic [DW-1:0]     remb0_ff;
   logic              ovfa0_ff;
   logic              ovfb0_ff;
   logic [PWD-1:0]    den0_ff;
   logic [SIDE_W-1:0] side0_ff;
   logic [DW-1:0]     den_top;

   assign den_top = DW'(in_den) << QW;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (en) begin
         v0_ff <= in_valid;
      end
      if (en) begin
         rema0_ff <= DW'(in_num_a);
         remb0_ff <= DW'(in_num_b);
         ovfa0_ff <= DW'(in_num_a) >= den_top;
         ovfb0_ff <= DW'(in_num_b) >= den_top;
         den0_ff  <= in_den;
         side0_ff <= in_side;
      end
   end

   assign v_s[0]    = v0_ff;
   assign rema_s[0] = rema0_ff;
   assign remb_s[0] = remb0_ff;
   assign quoa_s[0] = '0;
   assign quob_s[0] = '0;
   assign ovfa_s[0] = ovfa0_ff;
   assign ovfb_s[0] = ovfb0_ff;
   assign den_s[0]  = den0_ff;
   assign side_s[0] = side0_ff;

   for (genvar j = 0; j < QW; j++) begin : g_step
      localparam int BIT_POS = QW - 1 - j;
      logic              v_ff;
      logic [DW-1:0]     rema_ff;
      logic [DW-1:0]     remb_ff;
      logic [QW-1:0]     quoa_ff;
      logic [QW-1:0]     quob_ff;
      logic              ovfa_ff;
      logic              ovfb_ff;
      logic [PWD-1:0]    den_ff;
      logic [SIDE_W-1:0] side_ff;
      logic [DW-1:0]     den_sh;
      logic [DW-1:0]     rema_in;
      logic [DW-1:0]     remb_in;
      logic [QW-1:0]     quoa_in;
      logic [QW-1:0]     quob_in;

      always_comb begin
         den_sh  = DW'(den_s[j]) << BIT_POS;
         rema_in = rema_s[j];
         remb_in = remb_s[j];
         quoa_in = quoa_s[j];
         quob_in = quob_s[j];
         if (rema_s[j] >= den_sh) begin
            rema_in          = rema_s[j] - den_sh;
            quoa_in[BIT_POS] = 1'b1;
         end
         if (remb_s[j] >= den_sh) begin
            remb_in          = remb_s[j] - den_sh;
            quob_in[BIT_POS] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_s[j];
         end
         if (en) begin
            rema_ff <= rema_in;
            remb_ff <= remb_in;
            quoa_ff <= quoa_in;
            quob_ff <= quob_in;
            ovfa_ff <= ovfa_s[j];
            ovfb_ff <= ovfb_s[j];
            den_ff  <= den_s[j];
            side_ff <= side_s[j];
         end
      end

      assign v_s[j+1]    = v_ff;
      assign rema_s[j+1] = rema_ff;
      assign remb_s[j+1] = remb_ff;
      assign quoa_s[j+1] = quoa_ff;
      assign quob_s[j+1] = quob_ff;
      assign ovfa_s[j+1] = ovfa_ff;
      assign ovfb_s[j+1] = ovfb_ff;
      assign den_s[j+1]  = den_ff;
      assign side_s[j+1] = side_ff;
   end

   assign out_valid = v_s[QW];
   assign out_quo_a = quoa_s[QW];
   assign out_quo_b = quob_s[QW];
   assign out_ovf_a = ovfa_s[QW];
   assign out_ovf_b = ovfb_s[QW];
   assign out_side  = side_s[QW];

endmodule

### hw/rtl/rdlf_out_buf.sv
// Output register with a skid stage that decouples the pipeline from the result channel.
module rdlf_out_buf
   import rdlf_pkg::*;
#(
   parameter int W = OUT_FIELDS * FIELD_W
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push_valid,
   input  logic [W-1:0] push_data,
   output logic         skid_full,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [W-1:0] rsp_tdata
);

   logic         out_valid_ff;
   logic [W-1:0] out_data_ff;
   logic         skid_valid_ff;
   logic [W-1:0] skid_data_ff;
   logic         push;

   assign push = push_valid && !skid_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!out_valid_ff || rsp_tready) begin
         if (skid_valid_ff) begin
            out_valid_ff  <= 1'b1;
            out_data_ff   <= skid_data_ff;
            skid_valid_ff <= 1'b0;
         end else begin
            out_valid_ff <= push;
            out_data_ff  <= push_data;
         end
      end else if (push) begin
         skid_valid_ff <= 1'b1;
         skid_data_ff  <= push_data;
      end
   end

   assign skid_full  = skid_valid_ff;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

endmodule

### hw/rtl/rotate_direction_to_lab_frame.sv
// Top level of the pipelined rotation of a direction into the lab frame.
// Accepts one beat per clock while req_tready is high and returns one result beat per input
// beat, in order; the default format is Q1.30. The square-root pipeline (one root bit per
// stage) and the divider pipeline (one quotient bit per stage) run one after the other, with
// stages 4 and 5 between them. All fields are signed fixed point with FRAC_BITS fraction bits;
// inputs are clamped to unit range before use and results saturate to unit range. A stalled
// result channel freezes the whole pipeline once the skid stage behind the output register fills.
module rotate_direction_to_lab_frame
   import rdlf_pkg::*;
#(
   parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_tvalid,
   output logic                             req_tready,
   // dir_x, dir_y, dir_z, ref_x, ref_y, ref_z, 32 bits each from the lowest bit up.
   input  logic [IN_FIELDS*FIELD_W-1:0]     req_tdata,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   // lab_x, lab_y, lab_z, 32 bits each from the lowest bit up.
   output logic [OUT_FIELDS*FIELD_W-1:0]    rsp_tdata
);

   localparam int VW = FRAC_BITS + 2;
   localparam int PW = 2 * VW;
   localparam int SW = 2 * FRAC_BITS + 2;
   localparam int RW = FRAC_BITS + 1;
   localparam int NW = 2 * FRAC_BITS + 2;
   localparam int QW = FRAC_BITS + 3;
   localparam int OW = OUT_FIELDS * FIELD_W;

   localparam logic signed [FIELD_W-1:0] ONE_IN = {{(FIELD_W-1){1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic signed [FIELD_W-1:0] NEG_ONE_IN = -ONE_IN;
   localparam logic signed [PW-1:0] ONE_P = {{(PW-1){1'b0}}, 1'b1} << FRAC_BITS;
   localparam logic signed [PW-1:0] NEG_ONE_P = -ONE_P;
   localparam logic signed [PW-1:0] HALF_P = {{(PW-1){1'b0}}, 1'b1} << (FRAC_BITS - 1);

   typedef struct packed {
      logic signed [PW-1:0] adx;
      logic signed [PW-1:0] bdx;
      logic signed [PW-1:0] pydy;
      logic signed [PW-1:0] pxdy;
      logic signed [PW-1:0] pzdz;
      logic signed [VW-1:0] sxdz;
      logic signed [VW-1:0] sydz;
      logic signed [VW-1:0] dx;
      logic signed [VW-1:0] dy;
      logic signed [VW-1:0] dz;
      logic                 zero;
      logic                 rzneg;
   } sq_side_type;

   typedef struct packed {
      logic                 negx;
      logic                 negy;
      logic signed [VW-1:0] sxdz;
      logic signed [VW-1:0] sydz;
      logic signed [VW-1:0] lz;
      logic signed [VW-1:0] dx;
      logic signed [VW-1:0] dy;
      logic signed [VW-1:0] dz;
      logic                 zero;
      logic                 rzneg;
   } dv_side_type;

   localparam int SQ_W = $bits(sq_side_type);
   localparam int DV_W = $bits(dv_side_type);

   function automatic logic signed [VW-1:0] clamp_in(input logic signed [FIELD_W-1:0] v);
      logic signed [VW-1:0] r;
      if (v > ONE_IN) begin
         r = $signed(ONE_IN[VW-1:0]);
      end else if (v < NEG_ONE_IN) begin
         r = $signed(NEG_ONE_IN[VW-1:0]);
      end else begin
         r = $signed(v[VW-1:0]);
      end
      return r;
   endfunction

   function automatic logic signed [PW-1:0] sround(input logic signed [PW-1:0] v);
      logic signed [PW-1:0] t;
      t = v + HALF_P - $signed({{(PW-1){1'b0}}, v[PW-1]});
      return t >>> FRAC_BITS;
   endfunction

   function automatic logic signed [VW-1:0] sat_unit(input logic signed [PW-1:0] v);
      logic signed [VW-1:0] r;
      if (v > ONE_P) begin
         r = $signed(ONE_P[VW-1:0]);
      end else if (v < NEG_ONE_P) begin
         r = $signed(NEG_ONE_P[VW-1:0]);
      end else begin
         r = $signed(v[VW-1:0]);
      end
      return r;
   endfunction

   logic pipe_en;
   logic skid_full;

   assign pipe_en    = !skid_full;
   assign req_tready = pipe_en;

   // Stage 0: clamp.
   logic                 v0_ff;
   logic signed [VW-1:0] dx0_ff, dy0_ff, dz0_ff, rx0_ff, ry0_ff, rz0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (pipe_en) begin
         v0_ff <= req_tvalid;
      end
      if (pipe_en) begin
         dx0_ff <= clamp_in($signed(req_tdata[0*FIELD_W +: FIELD_W]));
         dy0_ff <= clamp_in($signed(req_tdata[1*FIELD_W +: FIELD_W]));
         dz0_ff <= clamp_in($signed(req_tdata[2*FIELD_W +: FIELD_W]));
         rx0_ff <= clamp_in($signed(req_tdata[3*FIELD_W +: FIELD_W]));
         ry0_ff <= clamp_in($signed(req_tdata[4*FIELD_W +: FIELD_W]));
         rz0_ff <= clamp_in($signed(req_tdata[5*FIELD_W +: FIELD_W]));
      end
   end

   // Stage 1: products.
   logic                 v1_ff, zero1_ff, rzneg1_ff;
   logic signed [PW-1:0] pxx1_ff, pyy1_ff, pxz1_ff, pyz1_ff, pxdz1_ff, pydz1_ff;
   logic signed [PW-1:0] pzdz1_ff, pydy1_ff, pxdy1_ff;
   logic signed [VW-1:0] dx1_ff, dy1_ff, dz1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (pipe_en) begin
         v1_ff <= v0_ff;
      end
      if (pipe_en) begin
         pxx1_ff   <= rx0_ff * rx0_ff;
         pyy1_ff   <= ry0_ff * ry0_ff;
         pxz1_ff   <= rx0_ff * rz0_ff;
         pyz1_ff   <= ry0_ff * rz0_ff;
         pxdz1_ff  <= rx0_ff * dz0_ff;
         pydz1_ff  <= ry0_ff * dz0_ff;
         pzdz1_ff  <= rz0_ff * dz0_ff;
         pydy1_ff  <= ry0_ff * dy0_ff;
         pxdy1_ff  <= rx0_ff * dy0_ff;
         dx1_ff    <= dx0_ff;
         dy1_ff    <= dy0_ff;
         dz1_ff    <= dz0_ff;
         zero1_ff  <= (rx0_ff == '0) && (ry0_ff == '0);
         rzneg1_ff <= rz0_ff[VW-1];
      end
   end

   // Stage 2: radius sum and rounded rescaling.
   logic                 v2_ff, zero2_ff, rzneg2_ff;
   logic [SW-1:0]        sum2_ff;
   logic signed [VW-1:0] a2_ff, b2_ff, sxdz2_ff, sydz2_ff, dx2_ff, dy2_ff, dz2_ff;
   logic signed [PW-1:0] pzdz2_ff, pydy2_ff, pxdy2_ff;
   logic signed [PW-1:0] sum2_in, a2_in, b2_in, sxdz2_in, sydz2_in;

   always_comb begin
      sum2_in  = pxx1_ff + pyy1_ff;
      a2_in    = sround(pxz1_ff);
      b2_in    = sround(pyz1_ff);
      sxdz2_in = sround(pxdz1_ff);
      sydz2_in = sround(pydz1_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (pipe_en) begin
         v2_ff <= v1_ff;
      end
      if (pipe_en) begin
         sum2_ff   <= sum2_in[SW-1:0];
         a2_ff     <= a2_in[VW-1:0];
         b2_ff     <= b2_in[VW-1:0];
         sxdz2_ff  <= sxdz2_in[VW-1:0];
         sydz2_ff  <= sydz2_in[VW-1:0];
         pzdz2_ff  <= pzdz1_ff;
         pydy2_ff  <= pydy1_ff;
         pxdy2_ff  <= pxdy1_ff;
         dx2_ff    <= dx1_ff;
         dy2_ff    <= dy1_ff;
         dz2_ff    <= dz1_ff;
         zero2_ff  <= zero1_ff;
         rzneg2_ff <= rzneg1_ff;
      end
   end

   // Stage 3: numerator products.
   logic          v3_ff;
   logic [SW-1:0] sum3_ff;
   sq_side_type   sq3_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (pipe_en) begin
         v3_ff <= v2_ff;
      end
      if (pipe_en) begin
         sum3_ff      <= sum2_ff;
         sq3_ff.adx   <= a2_ff * dx2_ff;
         sq3_ff.bdx   <= b2_ff * dx2_ff;
         sq3_ff.pydy  <= pydy2_ff;
         sq3_ff.pxdy  <= pxdy2_ff;
         sq3_ff.pzdz  <= pzdz2_ff;
         sq3_ff.sxdz  <= sxdz2_ff;
         sq3_ff.sydz  <= sydz2_ff;
         sq3_ff.dx    <= dx2_ff;
         sq3_ff.dy    <= dy2_ff;
         sq3_ff.dz    <= dz2_ff;
         sq3_ff.zero  <= zero2_ff;
         sq3_ff.rzneg <= rzneg2_ff;
      end
   end

   logic              sq_valid;
   logic [RW-1:0]     sq_root;
   logic [SQ_W-1:0]   sq_side_bits;
   sq_side_type       sq_side;

   rdlf_sqrt #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (SQ_W)
   ) u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (v3_ff),
      .in_sum    (sum3_ff),
      .in_side   (sq3_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side_bits)
   );

   assign sq_side = sq_side_type'(sq_side_bits);

   // Stage 4: numerators and p * dir_x.
   logic                 v4_ff, zero4_ff, rzneg4_ff;
   logic [RW-1:0]        p4_ff;
   logic signed [PW-1:0] nx4_ff, ny4_ff, pdx4_ff, pzdz4_ff;
   logic signed [VW-1:0] sxdz4_ff, sydz4_ff, dx4_ff, dy4_ff, dz4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (pipe_en) begin
         v4_ff <= sq_valid;
      end
      if (pipe_en) begin
         p4_ff     <= sq_root;
         nx4_ff    <= sq_side.adx - sq_side.pydy;
         ny4_ff    <= sq_side.bdx + sq_side.pxdy;
         pdx4_ff   <= $signed({1'b0, sq_root}) * sq_side.dx;
         pzdz4_ff  <= sq_side.pzdz;
         sxdz4_ff  <= sq_side.sxdz;
         sydz4_ff  <= sq_side.sydz;
         dx4_ff    <= sq_side.dx;
         dy4_ff    <= sq_side.dy;
         dz4_ff    <= sq_side.dz;
         zero4_ff  <= sq_side.zero;
         rzneg4_ff <= sq_side.rzneg;
      end
   end

   // Stage 5: lab_z and numerator magnitudes with the rounding offset.
   logic                 v5_ff;
   logic [NW-1:0]        numx5_ff, numy5_ff;
   logic [RW-1:0]        p5_ff;
   dv_side_type          dv5_ff;
   logic signed [PW-1:0] absx5, absy5, offs5;

   always_comb begin
      offs5 = PW'({1'b0, p4_ff} >> 1);
      absx5 = (nx4_ff[PW-1] ? -nx4_ff : nx4_ff) + offs5;
      absy5 = (ny4_ff[PW-1] ? -ny4_ff : ny4_ff) + offs5;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v5_ff <= 1'b0;
      end else if (pipe_en) begin
         v5_ff <= v4_ff;
      end
      if (pipe_en) begin
         numx5_ff     <= absx5[NW-1:0];
         numy5_ff     <= absy5[NW-1:0];
         p5_ff        <= p4_ff;
         dv5_ff.negx  <= nx4_ff[PW-1];
         dv5_ff.negy  <= ny4_ff[PW-1];
         dv5_ff.sxdz  <= sxdz4_ff;
         dv5_ff.sydz  <= sydz4_ff;
         dv5_ff.lz    <= sat_unit(sround(pzdz4_ff - pdx4_ff));
         dv5_ff.dx    <= dx4_ff;
         dv5_ff.dy    <= dy4_ff;
         dv5_ff.dz    <= dz4_ff;
         dv5_ff.zero  <= zero4_ff;
         dv5_ff.rzneg <= rzneg4_ff;
      end
   end

   logic              dv_valid, dv_ovf_x, dv_ovf_y;
   logic [QW-1:0]     dv_quo_x, dv_quo_y;
   logic [DV_W-1:0]   dv_side_bits;
   dv_side_type       dv_side;

   rdlf_div #(
      .FRAC_BITS (FRAC_BITS),
      .SIDE_W    (DV_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (pipe_en),
      .in_valid  (v5_ff),
      .in_num_a  (numx5_ff),
      .in_num_b  (numy5_ff),
      .in_den    (p5_ff),
      .in_side   (dv5_ff),
      .out_valid (dv_valid),
      .out_quo_a (dv_quo_x),
      .out_quo_b (dv_quo_y),
      .out_ovf_a (dv_ovf_x),
      .out_ovf_b (dv_ovf_y),
      .out_side  (dv_side_bits)
   );

   assign dv_side = dv_side_type'(dv_side_bits);

   // Stage 6: signed quotient plus rescaled dir_z term, saturation and axis cases.
   logic                 v6_ff;
   logic [OW-1:0]        res6_ff;
   logic [QW-1:0]        qx6, qy6;
   logic signed [QW+1:0] sqx6, sqy6;
   logic signed [PW-1:0] lx6, ly6;
   logic signed [VW-1:0] ox6, oy6, oz6;

   always_comb begin
      qx6  = dv_ovf_x ? '1 : dv_quo_x;
      qy6  = dv_ovf_y ? '1 : dv_quo_y;
      sqx6 = $signed({2'b00, qx6});
      sqy6 = $signed({2'b00, qy6});
      if (dv_side.negx) begin
         sqx6 = -sqx6;
      end
      if (dv_side.negy) begin
         sqy6 = -sqy6;
      end
      lx6 = PW'(sqx6) + PW'(dv_side.sxdz);
      ly6 = PW'(sqy6) + PW'(dv_side.sydz);
      if (!dv_side.zero) begin
         ox6 = sat_unit(lx6);
         oy6 = sat_unit(ly6);
         oz6 = dv_side.lz;
      end else if (dv_side.rzneg) begin
         ox6 = -dv_side.dx;
         oy6 = dv_side.dy;
         oz6 = -dv_side.dz;
      end else begin
         ox6 = dv_side.dx;
         oy6 = dv_side.dy;
         oz6 = dv_side.dz;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (pipe_en) begin
         v6_ff <= dv_valid;
      end
      if (pipe_en) begin
         res6_ff <= {FIELD_W'(oz6), FIELD_W'(oy6), FIELD_W'(ox6)};
      end
   end

   rdlf_out_buf #(
      .W (OW)
   ) u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push_valid (v6_ff),
      .push_data  (res6_ff),
      .skid_full  (skid_full),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   a_lab_x_unit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[FIELD_W-1:0]) <= ONE_IN &&
                      $signed(rsp_tdata[FIELD_W-1:0]) >= NEG_ONE_IN))
      else $error("lab_x outside unit range");

   a_lab_z_unit : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ($signed(rsp_tdata[3*FIELD_W-1:2*FIELD_W]) <= ONE_IN &&
                      $signed(rsp_tdata[3*FIELD_W-1:2*FIELD_W]) >= NEG_ONE_IN))
      else $error("lab_z outside unit range");

   a_stall_has_result : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid)
      else $error("input stalled with no result waiting");

   a_stall_freezes : assert property (@(posedge clock) disable iff (reset)
      !pipe_en && !$past(reset) |=> $stable(v6_ff) && $stable(res6_ff))
      else $error("pipeline moved while stalled");

endmodule
